// ===== rtl/bc1_pkg.sv =====
`timescale 1ns / 1ps

package bc1_pkg;

  // Register file layout
  localparam int CFG_W = 11;

  typedef enum logic [0:0] {
    CFG_WIDTH_BLOCKS  = 1'b0,
    CFG_HEIGHT_BLOCKS = 1'b1
  } cfg_reg_e;

  // Default image side limit in blocks
  localparam int MAX_BLOCKS_DEFAULT = 1024;

  // Field widths
  localparam int COLOR_W = 16;
  localparam int INDEX_W = 32;
  localparam int PIXEL_W = 24;
  localparam int COORD_W = 12;

  // Stream payload widths
  localparam int IN_DATA_W  = 2 * COLOR_W + INDEX_W;
  localparam int OUT_DATA_W = 4 * PIXEL_W + 2 * COORD_W;

  // Index of the last pixel row in a block
  localparam logic [1:0] LAST_ROW = 2'd3;

  typedef logic [3:0][PIXEL_W-1:0] pal_t;

  // One decoded block waiting to be sent out row by row
  typedef struct packed {
    pal_t               pal;
    logic [INDEX_W-1:0] idx;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] ybase;
    logic               wraps;
  } block_t;

endpackage

// ===== rtl/bc1_palette.sv =====
`timescale 1ns / 1ps

module bc1_palette import bc1_pkg::*; (
  input  logic [COLOR_W-1:0] col_a_i,
  input  logic [COLOR_W-1:0] col_b_i,
  output pal_t               pal_o
);

  // Floor of v / 3 for v up to 765: multiply by 683 / 2048
  function automatic logic [7:0] div3(input logic [9:0] v);
    logic [20:0] prod;
    prod = 21'(v) * 21'd683;
    return prod[18:11];
  endfunction

  logic [7:0] r0, g0, b0, r1, g1, b1;
  logic [7:0] r2, g2, b2, r3, g3, b3;
  logic [8:0] rh, gh, bh;
  logic       four_color;

  // Widen RGB565 by replicating the top bits
  assign r0 = {col_a_i[15:11], col_a_i[15:13]};
  assign g0 = {col_a_i[10:5],  col_a_i[10:9]};
  assign b0 = {col_a_i[4:0],   col_a_i[4:2]};
  assign r1 = {col_b_i[15:11], col_b_i[15:13]};
  assign g1 = {col_b_i[10:5],  col_b_i[10:9]};
  assign b1 = {col_b_i[4:0],   col_b_i[4:2]};

  assign four_color = col_a_i > col_b_i;

  // Half blends for the three-color mode
  assign rh = 9'(r0) + 9'(r1);
  assign gh = 9'(g0) + 9'(g1);
  assign bh = 9'(b0) + 9'(b1);

  // Build entries two and three
  always_comb begin
    if (four_color) begin
      r2 = div3({1'b0, r0, 1'b0} + 10'(r1));
      g2 = div3({1'b0, g0, 1'b0} + 10'(g1));
      b2 = div3({1'b0, b0, 1'b0} + 10'(b1));
      r3 = div3(10'(r0) + {1'b0, r1, 1'b0});
      g3 = div3(10'(g0) + {1'b0, g1, 1'b0});
      b3 = div3(10'(b0) + {1'b0, b1, 1'b0});
    end else begin
      r2 = rh[8:1];
      g2 = gh[8:1];
      b2 = bh[8:1];
      r3 = '0;
      g3 = '0;
      b3 = '0;
    end
  end

  assign pal_o[0] = {r0, g0, b0};
  assign pal_o[1] = {r1, g1, b1};
  assign pal_o[2] = {r2, g2, b2};
  assign pal_o[3] = {r3, g3, b3};

endmodule

// ===== rtl/bc1_row_ser.sv =====
`timescale 1ns / 1ps

module bc1_row_ser import bc1_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               blk_valid_i,
  input  block_t             blk_i,
  output logic               blk_take_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pal_t               out_pix_o,
  output logic [COORD_W-1:0] out_x_o,
  output logic [COORD_W-1:0] out_y_o,
  output logic               out_block_done_o,
  output logic               out_image_done_o
);

  block_t             blk_q;
  logic               bvalid_q, bvalid_d;
  logic [1:0]         row_q;
  logic               ovalid_q, ovalid_d;
  pal_t               opix_q, opix_d;
  logic [COORD_W-1:0] ox_q;
  logic [COORD_W-1:0] oy_q, oy_d;
  logic               obd_q, oid_q;
  logic               out_free, emit, last_row, load;
  logic [7:0]         row_bits;

  assign out_free   = !ovalid_q || out_ready_i;
  assign emit       = bvalid_q && out_free;
  assign last_row   = row_q == LAST_ROW;
  assign blk_take_o = !bvalid_q || (emit && last_row);
  assign load       = blk_valid_i && blk_take_o;

  // Look up the four pixels of the current row
  assign row_bits = blk_q.idx[{row_q, 3'b000} +: 8];
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      opix_d[c] = blk_q.pal[row_bits[2*c +: 2]];
    end
  end
  assign oy_d = blk_q.ybase | COORD_W'(row_q);

  // Hold block flag: set on load, drop after the last row leaves
  always_comb begin
    if (load) begin
      bvalid_d = 1'b1;
    end else if (emit && last_row) begin
      bvalid_d = 1'b0;
    end else begin
      bvalid_d = bvalid_q;
    end
  end

  // Output register flag
  always_comb begin
    if (emit) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end else begin
      ovalid_d = ovalid_q;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvalid_q <= 1'b0;
      ovalid_q <= 1'b0;
      row_q    <= '0;
    end else begin
      bvalid_q <= bvalid_d;
      ovalid_q <= ovalid_d;
      if (emit) begin
        row_q <= row_q + 2'd1;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      blk_q <= blk_i;
    end
    if (emit) begin
      opix_q <= opix_d;
      ox_q   <= blk_q.x;
      oy_q   <= oy_d;
      obd_q  <= last_row;
      oid_q  <= last_row && blk_q.wraps;
    end
  end

  assign out_valid_o      = ovalid_q;
  assign out_pix_o        = opix_q;
  assign out_x_o          = ox_q;
  assign out_y_o          = oy_q;
  assign out_block_done_o = obd_q;
  assign out_image_done_o = oid_q;

  // A block in progress always has its flag set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q != 2'd0) |-> bvalid_q)
    else $error("row counter running without a block");

  // A block is released only after its last row was sent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(bvalid_q) |-> $past(emit && last_row))
    else $error("block dropped before its last row");

  // The image end flag comes only with the block end flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && oid_q) |-> obd_q)
    else $error("image end without block end");

endmodule

// ===== rtl/bc1_texture_block_decode.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Payload (tdata / tuser / tlast)
// s_axis    in   one compressed 4x4 block per request
// m_axis    out  one decoded pixel row per request, four per block
// cfg       in   width_blocks (index 0), height_blocks (index 1)
//
// The row serializer sends one pixel row per cycle while the output is not stalled.
// The first row passes through the input register, the row holder and the output
// register before it is offered.
// An input register sits ahead of the row holder, so a new block is taken
// while rows of the previous one wait on a stalled output.
// Reset clears the block position counters and sets both sizes to one block.

module bc1_texture_block_decode import bc1_pkg::*; #(
  parameter int MAX_BLOCKS_PER_SIDE = MAX_BLOCKS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // end_colour_a [15:0], end_colour_b [31:16], index_bits [63:32]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // pixel_col0..pixel_col3 [95:0], pixel_x [107:96], pixel_y [119:108]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // block_done
  output logic                  m_axis_tuser,
  output logic                  m_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic                  cfg_we_i,
  input  cfg_reg_e              cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i
);

  localparam int CW = (MAX_BLOCKS_PER_SIDE > 1) ? $clog2(MAX_BLOCKS_PER_SIDE) : 1;
  localparam int EW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam logic [EW-1:0] MaxEff = EW'(MAX_BLOCKS_PER_SIDE);

  logic [CFG_W-1:0] width_q, height_q;
  logic [CW-1:0]    col_q, row_q;
  logic [EW-1:0]    w_eff, h_eff;
  logic             last_col, last_row, s_accept;
  logic             avalid_q, avalid_d;
  block_t           ablk_q, ablk_d;
  pal_t             pal;
  logic             blk_take;
  pal_t             out_pix;
  logic [COORD_W-1:0] out_x, out_y;
  logic             out_bd, out_id;
  logic [CW+13:0]   x_wide, y_wide;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(1);
      height_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIDTH_BLOCKS:  width_q  <= cfg_wdata_i;
        CFG_HEIGHT_BLOCKS: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamp sizes: zero acts as one, large values as the limit
  always_comb begin
    if (width_q == '0) begin
      w_eff = EW'(1);
    end else if (EW'(width_q) > MaxEff) begin
      w_eff = MaxEff;
    end else begin
      w_eff = EW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = EW'(1);
    end else if (EW'(height_q) > MaxEff) begin
      h_eff = MaxEff;
    end else begin
      h_eff = EW'(height_q);
    end
  end

  assign last_col = (EW'(col_q) + EW'(1)) >= w_eff;
  assign last_row = (EW'(row_q) + EW'(1)) >= h_eff;

  assign s_axis_tready = !avalid_q || blk_take;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // Advance block position on each accepted block
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (s_accept) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + CW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  bc1_palette u_palette (
    .col_a_i (s_axis_tdata[COLOR_W-1:0]),
    .col_b_i (s_axis_tdata[2*COLOR_W-1:COLOR_W]),
    .pal_o   (pal)
  );

  // Assemble the block for the input register
  assign x_wide = (CW + 14)'(col_q) << 2;
  assign y_wide = (CW + 14)'(row_q) << 2;
  always_comb begin
    ablk_d.pal   = pal;
    ablk_d.idx   = s_axis_tdata[IN_DATA_W-1:2*COLOR_W];
    ablk_d.x     = x_wide[COORD_W-1:0];
    ablk_d.ybase = y_wide[COORD_W-1:0];
    ablk_d.wraps = last_col && last_row;
  end

  always_comb begin
    if (s_accept) begin
      avalid_d = 1'b1;
    end else if (blk_take) begin
      avalid_d = 1'b0;
    end else begin
      avalid_d = avalid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avalid_q <= 1'b0;
    end else begin
      avalid_q <= avalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      ablk_q <= ablk_d;
    end
  end

  bc1_row_ser u_row_ser (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .blk_valid_i      (avalid_q),
    .blk_i            (ablk_q),
    .blk_take_o       (blk_take),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_pix_o        (out_pix),
    .out_x_o          (out_x),
    .out_y_o          (out_y),
    .out_block_done_o (out_bd),
    .out_image_done_o (out_id)
  );

  assign m_axis_tdata = {out_y, out_x, out_pix};
  assign m_axis_tuser = out_bd;
  assign m_axis_tlast = out_id;

  // Block position stays inside the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (EW'(col_q) < MaxEff) && (EW'(row_q) < MaxEff))
    else $error("block position beyond the side limit");

  // A wrapping block returns the position to the origin
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && last_col && last_row) |=> (col_q == '0) && (row_q == '0))
    else $error("position did not wrap after the last block");

endmodule
